// File: rtl/cta_pkg.sv
// Shared types, widths and constants for the capacitive-sense trimmed accumulator.
// No dependencies; every other file of the block refers to this package.
package cta_pkg;

  // Field widths
  localparam int COUNT_W  = 32;   // countdown value and timeout
  localparam int SC_W     = 8;    // sample_count register
  localparam int SUM_W    = 29;   // running sum and result value
  localparam int MIN_W    = 24;   // smallest scaled value seen
  localparam int MAX_W    = 23;   // largest scaled value seen
  localparam int CNT_W    = 7;    // samples taken in the current burst
  localparam int BURST_W  = SC_W + 1;
  localparam int CFG_IDX_W = 1;

  // Defaults and limits
  localparam int SCALE_DIVISOR = 1000;
  localparam int MAX_BURST     = 102;
  localparam logic [MIN_W-1:0] MIN_RESET = 24'hFFFFFF;
  localparam logic [SC_W-1:0]  SAMPLE_COUNT_RESET = 8'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 1'b0,
    CFG_TIMEOUT      = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SC_W-1:0]    sample_count;
    logic [COUNT_W-1:0] timeout_cycles;
  } cfg_t;

  // Bits needed for floor((2^32-1) / divisor)
  function automatic int scaled_width(int divisor);
    return 33 - $clog2(divisor + 1);
  endfunction

endpackage

// File: rtl/capsense_trimmed_accumulator_unit.sv
// Path: the input transaction that completes a result passes the two-multiply
// divide-by-constant pipeline (5 stages), then the accumulator and result register.
// Throughput: one input transaction per cycle unless in_stall is raised by a held
// result backing up the pipeline.
// Reset (rst_n low, synchronous): pipeline and result empty, sum/max/count zero,
// min all ones, sample_count 1, timeout_cycles 0. Depends on cta_pkg, cta_scale, cta_accum.
module capsense_trimmed_accumulator_unit #(
  parameter int SCALE_DIVISOR = cta_pkg::SCALE_DIVISOR
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cta_pkg::COUNT_W-1:0]    in_count_left,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cta_pkg::SUM_W-1:0]      out_result_value,
  output logic [1:0]                     out_status,
  // configuration write port
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cta_pkg::COUNT_W-1:0]    cfg_data
);

  localparam int SCALED_W = cta_pkg::scaled_width(SCALE_DIVISOR);

  cta_pkg::cfg_t      cfg_r;
  cta_pkg::status_t   acc_status;

  // scaler -> accumulator transaction
  logic                acc_valid;
  logic                acc_ready;
  logic [SCALED_W-1:0] acc_scaled;
  logic                acc_zero;

  // Configuration registers. Writes are always taken; software must write them only
  // while no transaction is in flight (not enforced here), so the pipeline sees stable values.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count   <= cta_pkg::SAMPLE_COUNT_RESET;
      cfg_r.timeout_cycles <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cta_pkg::cfg_reg_t'(cfg_index))
        cta_pkg::CFG_SAMPLE_COUNT: begin
          cfg_r.sample_count <= cfg_data[cta_pkg::SC_W-1:0];
        end
        cta_pkg::CFG_TIMEOUT: begin
          cfg_r.timeout_cycles <= cfg_data;
        end
      endcase
    end
  end

  // Elapsed = timeout - count_left (mod 2^32), then floor(elapsed / divisor)
  // via reciprocal multiply, back-multiply and a single +1 correction.
  cta_scale #(
    .SCALE_DIVISOR (SCALE_DIVISOR),
    .SCALED_W      (SCALED_W)
  ) u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .timeout_cycles (cfg_r.timeout_cycles),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_count_left  (in_count_left),
    .out_valid      (acc_valid),
    .out_ready      (acc_ready),
    .out_scaled     (acc_scaled),
    .out_zero       (acc_zero)
  );

  // Burst bookkeeping and the result register. Transactions that finish no
  // burst pass through even while a result is held, so the pipeline keeps
  // draining behind a stalled output.
  cta_accum #(
    .SCALE_DIVISOR (SCALE_DIVISOR),
    .SCALED_W      (SCALED_W)
  ) u_accum (
    .clk              (clk),
    .rst_n            (rst_n),
    .sample_count     (cfg_r.sample_count),
    .in_valid         (acc_valid),
    .in_ready         (acc_ready),
    .in_scaled        (acc_scaled),
    .in_zero          (acc_zero),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (acc_status)
  );

  assign out_status = acc_status;

  // Error results always carry a zero value
  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != cta_pkg::ST_OK)) |-> (out_result_value == '0))
    else $error("error result with nonzero value");

  // Input back-pressure only comes from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output is free");

  // A new result needs an accumulator transaction in the cycle before
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> $past(acc_valid && acc_ready))
    else $error("result appeared without an accumulator transaction");

endmodule

// File: rtl/cta_scale.sv
// Elapsed-count and constant-divide pipeline: input register, subtract, reciprocal
// multiply, back-multiply, correction. Depends on cta_pkg.
module cta_scale #(
  parameter int SCALE_DIVISOR = cta_pkg::SCALE_DIVISOR,
  parameter int SCALED_W      = cta_pkg::scaled_width(SCALE_DIVISOR)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cta_pkg::COUNT_W-1:0]  timeout_cycles,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cta_pkg::COUNT_W-1:0]  in_count_left,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SCALED_W-1:0]          out_scaled,
  output logic                         out_zero
);

  localparam int CW       = cta_pkg::COUNT_W;
  localparam int DIV_LOG  = $clog2(SCALE_DIVISOR);
  localparam int SHIFT    = 31 + DIV_LOG;
  localparam int DIV_W    = $clog2(SCALE_DIVISOR + 1);
  localparam int QD_W     = SCALED_W + DIV_W;
  localparam logic [63:0] MAGIC_FULL = (64'd1 << SHIFT) / 64'(SCALE_DIVISOR);
  localparam logic [CW-1:0] MAGIC    = MAGIC_FULL[CW-1:0];
  localparam logic [DIV_W-1:0] DIVISOR = DIV_W'(SCALE_DIVISOR);
  localparam logic [CW-1:0] DIVISOR_EXT = CW'(SCALE_DIVISOR);
  localparam int NSTG = 5;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  logic [CW-1:0]       left_r;
  logic [CW-1:0]       el1_r, el2_r, el3_r;
  logic                z1_r, z2_r, z3_r, z4_r;
  logic [63:0]         prod2_r;
  logic [SCALED_W-1:0] q3_r, sc4_r;
  logic [CW-1:0]       qd3_r;

  logic [CW-1:0]       el1_nxt;
  logic [63:0]         prod2_nxt;
  logic [SCALED_W-1:0] q3_nxt, sc4_nxt;
  logic [QD_W-1:0]     qd_full;
  logic [CW-1:0]       rem;

  // Bubble-collapsing ready chain
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_comb begin
    el1_nxt   = timeout_cycles - left_r;
    prod2_nxt = 64'(el1_r) * 64'(MAGIC);
    q3_nxt    = prod2_r[SHIFT +: SCALED_W];
    qd_full   = QD_W'(q3_nxt) * QD_W'(DIVISOR);
    rem       = el3_r - qd3_r;
    sc4_nxt   = (rem >= DIVISOR_EXT) ? q3_r + SCALED_W'(1) : q3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      left_r <= in_count_left;
    end
    if (rdy[1]) begin
      el1_r <= el1_nxt;
      z1_r  <= (el1_nxt == '0);
    end
    if (rdy[2]) begin
      prod2_r <= prod2_nxt;
      el2_r   <= el1_r;
      z2_r    <= z1_r;
    end
    if (rdy[3]) begin
      q3_r  <= q3_nxt;
      qd3_r <= qd_full[CW-1:0];
      el3_r <= el2_r;
      z3_r  <= z2_r;
    end
    if (rdy[4]) begin
      sc4_r <= sc4_nxt;
      z4_r  <= z3_r;
    end
  end

  assign out_valid  = vld_r[NSTG-1];
  assign out_scaled = sc4_r;
  assign out_zero   = z4_r;

endmodule

// File: rtl/cta_accum.sv
// Burst accumulator: running sum, min, max, sample count, and the result register.
// Depends on cta_pkg.
module cta_accum #(
  parameter int SCALE_DIVISOR = cta_pkg::SCALE_DIVISOR,
  parameter int SCALED_W      = cta_pkg::scaled_width(SCALE_DIVISOR)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cta_pkg::SC_W-1:0]    sample_count,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [SCALED_W-1:0]         in_scaled,
  input  logic                        in_zero,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cta_pkg::SUM_W-1:0]   out_result_value,
  output cta_pkg::status_t            out_status
);

  localparam int CW = cta_pkg::COUNT_W;

  logic [cta_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [cta_pkg::MIN_W-1:0]   min_r, min_nxt;
  logic [cta_pkg::MAX_W-1:0]   max_r, max_nxt;
  logic [cta_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [cta_pkg::SUM_W-1:0]   res_r;
  cta_pkg::status_t            status_r;

  logic [cta_pkg::BURST_W-1:0] burst;
  logic                        too_many, single, done, emit, take, out_free;
  logic [CW-1:0]               sc_ext;
  logic [cta_pkg::SUM_W-1:0]   sum_acc, trimmed, res_val;
  logic [cta_pkg::MIN_W-1:0]   min_acc;
  logic [cta_pkg::MAX_W-1:0]   max_acc;
  logic [cta_pkg::CNT_W-1:0]   cnt_acc;
  cta_pkg::status_t            res_status;

  always_comb begin
    burst    = cta_pkg::BURST_W'(sample_count) + cta_pkg::BURST_W'(2);
    too_many = burst > cta_pkg::BURST_W'(cta_pkg::MAX_BURST);
    single   = sample_count == cta_pkg::SC_W'(1);
    sc_ext   = CW'(in_scaled);
    sum_acc  = sum_r + sc_ext[cta_pkg::SUM_W-1:0];
    min_acc  = (sc_ext < CW'(min_r)) ? sc_ext[cta_pkg::MIN_W-1:0] : min_r;
    max_acc  = (sc_ext > CW'(max_r)) ? sc_ext[cta_pkg::MAX_W-1:0] : max_r;
    cnt_acc  = cnt_r + cta_pkg::CNT_W'(1);
    done     = cta_pkg::BURST_W'(cnt_acc) >= burst;
    trimmed  = sum_acc - cta_pkg::SUM_W'(min_acc) - cta_pkg::SUM_W'(max_acc);

    emit       = 1'b1;
    res_val    = '0;
    res_status = cta_pkg::ST_OK;
    priority if (too_many) begin
      res_status = cta_pkg::ST_TOO_MANY;
    end else if (in_zero) begin
      res_status = cta_pkg::ST_ZERO;
    end else if (single) begin
      res_val = sc_ext[cta_pkg::SUM_W-1:0];
    end else if (done) begin
      res_val = trimmed;
    end else begin
      emit = 1'b0;
    end

    if (emit) begin
      sum_nxt = '0;
      min_nxt = cta_pkg::MIN_RESET;
      max_nxt = '0;
      cnt_nxt = '0;
    end else begin
      sum_nxt = sum_acc;
      min_nxt = min_acc;
      max_nxt = max_acc;
      cnt_nxt = cnt_acc;
    end
  end

  // A non-emitting item never waits on the result register
  assign out_free = !out_valid_r || !out_stall;
  assign in_ready = out_free || !emit;
  assign take     = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_free;
    if (take && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      min_r       <= cta_pkg::MIN_RESET;
      max_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        sum_r <= sum_nxt;
        min_r <= min_nxt;
        max_r <= max_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r    <= res_val;
      status_r <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign out_status       = status_r;

endmodule

// File: tb/tb_capsense_trimmed_accumulator_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for capsense_trimmed_accumulator_unit: countdown values in,
// trimmed burst sums and status codes out, checked against an in-bench predictor.
// Depends on cta_pkg and the RTL of the block.
module tb_capsense_trimmed_accumulator_unit;
  import cta_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 12;    // extra drain time after the last result
  localparam int IDLE_LIMIT   = 3000;  // watchdog: cycles with no transaction at all
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int RANDOM_ITEMS = 1650;
  localparam int REPORT_LIMIT = 10;

  // One result transaction as the block should present it
  typedef struct packed {
    logic [SUM_W-1:0] value;
    status_t          status;
  } reading_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [COUNT_W-1:0]   in_count_left = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [SUM_W-1:0]     out_result_value;
  logic [1:0]           out_status;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_SAMPLE_COUNT;
  logic [COUNT_W-1:0]   cfg_data      = '0;

  // Predictor copy of the registers and the burst accumulator (reset values)
  logic [SC_W-1:0]    model_samples = SAMPLE_COUNT_RESET;
  logic [COUNT_W-1:0] model_timeout = '0;
  logic [SUM_W-1:0]   sum_acc       = '0;
  logic [MIN_W-1:0]   min_acc       = MIN_RESET;
  logic [MAX_W-1:0]   max_acc       = '0;
  logic [CNT_W-1:0]   taken_acc     = '0;

  logic [COUNT_W-1:0] pending_counts[$];     // countdown values waiting to be offered
  reading_t           expected_readings[$];  // results owed by the block, oldest first

  int items_queued   = 0;
  int items_accepted = 0;
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  capsense_trimmed_accumulator_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_count_left    (in_count_left),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Every result clears the burst state
  function automatic void post_reading(input logic [SUM_W-1:0] value, input status_t status);
    reading_t r;
    r.value  = value;
    r.status = status;
    expected_readings.push_back(r);
    sum_acc   = '0;
    min_acc   = MIN_RESET;
    max_acc   = '0;
    taken_acc = '0;
  endfunction

  // Predict the effect of one accepted countdown value
  function automatic void predict_reading(input logic [COUNT_W-1:0] left);
    logic [BURST_W-1:0] burst;
    logic [COUNT_W-1:0] elapsed;
    logic [COUNT_W-1:0] scaled;
    burst = BURST_W'(model_samples) + BURST_W'(2);
    // oversized burst: every item is rejected before it is measured
    if (burst > MAX_BURST) begin
      post_reading('0, ST_TOO_MANY);
      return;
    end
    elapsed = model_timeout - left;  // wraps modulo 2^32
    // zero elapsed aborts whatever burst is running
    if (elapsed == 0) begin
      post_reading('0, ST_ZERO);
      return;
    end
    scaled = elapsed / SCALE_DIVISOR;
    if (model_samples == 1) begin
      post_reading(scaled[SUM_W-1:0], ST_OK);
      return;
    end
    sum_acc = sum_acc + scaled[SUM_W-1:0];
    if (scaled < COUNT_W'(min_acc)) min_acc = scaled[MIN_W-1:0];
    if (scaled > COUNT_W'(max_acc)) max_acc = scaled[MAX_W-1:0];
    taken_acc = taken_acc + 1'b1;
    // judged against the current sample_count, so a lowered count ends early
    if (BURST_W'(taken_acc) >= burst) post_reading(sum_acc - min_acc - max_acc, ST_OK);
  endfunction

  // Driver: offers queued countdown values, predicts on each accepted transaction
  always @(posedge clk) begin
    logic took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        predict_reading(in_count_left);
        items_accepted++;
      end
      // a held payload stays put until taken
      if (!in_valid || took) begin
        if (pending_counts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          in_count_left <= pending_counts.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction, drives receiver back-pressure
  always @(posedge clk) begin
    logic     stall_next;
    reading_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: value %0d status %0d", out_result_value, out_status);
        end else begin
          want = expected_readings.pop_front();
          if (out_result_value !== want.value || out_status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       want.value, want.status, out_result_value, out_status);
          end
        end
      end
      // long hold-off on request, counted here
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else begin
        stall_next = ($urandom_range(99) < recv_stall_pct);
      end
      out_stall <= stall_next;
    end
  end

  // Watchdog: any transaction on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [COUNT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SAMPLE_COUNT: model_samples = data[SC_W-1:0];
      CFG_TIMEOUT:      model_timeout = data;
      default: ;
    endcase
  endtask

  task automatic queue_count(input logic [COUNT_W-1:0] left);
    pending_counts.push_back(left);
    items_queued++;
  endtask

  // countdown value that gives the wanted elapsed count under the current timeout
  function automatic logic [COUNT_W-1:0] left_for(input logic [COUNT_W-1:0] elapsed);
    return model_timeout - elapsed;
  endfunction

  // Mostly measurable values across all magnitudes, a few zero-elapsed aborts
  function automatic logic [COUNT_W-1:0] random_count(input int zero_pct);
    logic [COUNT_W-1:0] span;
    int pick;
    if ($urandom_range(99) < zero_pct) return model_timeout;
    pick = $urandom_range(99);
    if (pick < 35)      span = $urandom;
    else if (pick < 50) span = $urandom_range(999, 1);
    else if (pick < 75) span = $urandom_range(200000, 1000);
    else if (pick < 90) span = $urandom_range(32'h00FF_FFFF, 1);
    else                span = 32'hFFFF_FFFF - $urandom_range(5000);
    return model_timeout - span;
  endfunction

  task automatic wait_results();
    while (items_accepted != items_queued || expected_readings.size() != 0) @(posedge clk);
  endtask

  // idle point: nothing in flight, including items that owe no result
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  initial begin
    int                 ph;
    int                 samples;
    int                 items;
    int                 zero_pct;
    int                 sent;
    logic [COUNT_W-1:0] tmo;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset config, single-sample mode, timeout 0 ---
    set_idling(0);
    queue_count(32'h0000_0000);          // zero elapsed
    queue_count(32'hFFFF_FFFF);          // elapsed 1, scales to 0
    queue_count(32'h0000_0001);          // elapsed all ones, largest scaled value
    queue_count(left_for(1000));         // exactly one unit
    queue_count(left_for(999));          // just below one unit
    queue_count(32'hAAAA_AAAA);
    queue_count(32'h5555_5555);
    settle();

    // two-item burst, trimmed sum is always zero; then aborts
    write_reg(CFG_SAMPLE_COUNT, 0);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    queue_count(32'h0000_0000);
    queue_count(32'd12345);
    queue_count(32'hFFFF_FFFF);          // zero elapsed with no burst running
    queue_count(32'd100);
    queue_count(32'hFFFF_FFFF);          // zero elapsed mid-burst
    settle();

    write_reg(CFG_SAMPLE_COUNT, 3);
    queue_count(left_for(32'hFFFF_FFFF));
    queue_count(left_for(5000));
    queue_count(left_for(5000));
    queue_count(left_for(2000000));
    queue_count(left_for(999));
    settle();

    // sample_count changed with a burst half done
    write_reg(CFG_SAMPLE_COUNT, 4);
    queue_count(left_for(3000));
    queue_count(left_for(7000));
    queue_count(left_for(11000));
    settle();
    write_reg(CFG_SAMPLE_COUNT, 2);      // next item brings the taken count to the new burst size
    queue_count(left_for(20000));
    settle();
    write_reg(CFG_SAMPLE_COUNT, 4);
    queue_count(left_for(40000));
    queue_count(left_for(60000));
    settle();
    write_reg(CFG_SAMPLE_COUNT, 1);      // back to single mode drops the partial burst
    queue_count(left_for(8000));
    settle();

    // oversized bursts, including a zero-elapsed item
    write_reg(CFG_SAMPLE_COUNT, 101);
    queue_count(left_for(9000));
    settle();
    write_reg(CFG_SAMPLE_COUNT, 255);
    queue_count(model_timeout);
    settle();

    // --- random phases ---
    ph   = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_idling(ph % 4);
      zero_pct = 2;
      if (ph == 2) begin
        // hold-off phase: every item gives a result so the block backs up
        samples = 1;
        items   = 200;
        set_idling(0);
      end else if (ph == 6) begin
        samples  = 100;                   // largest legal burst, two of them
        items    = 2 * (samples + 2);
        zero_pct = 0;
      end else if (ph == 11) begin
        samples = 255;
        items   = 24;
      end else if (ph == 17) begin
        samples = 101;
        items   = 24;
      end else begin
        if (ph == 9) samples = 0;
        else if ($urandom_range(1) == 1) samples = 1;
        else samples = $urandom_range(12);
        // an odd leftover carries a partial burst into the next setting
        items = (samples + 2) * $urandom_range(8, 3) + $urandom_range(2);
      end
      case ($urandom_range(3))
        0:       tmo = '0;
        1:       tmo = 32'hFFFF_FFFF;
        default: tmo = $urandom;
      endcase
      write_reg(CFG_SAMPLE_COUNT, samples);
      write_reg(CFG_TIMEOUT, tmo);

      if (ph == 4) begin
        // sender pauses mid-phase until every owed result is back
        for (int i = 0; i < items / 2; i++) queue_count(random_count(zero_pct));
        wait_results();
        for (int i = items / 2; i < items; i++) queue_count(random_count(zero_pct));
      end else begin
        for (int i = 0; i < items; i++) queue_count(random_count(zero_pct));
      end
      if (ph == 2) hold_requests++;
      sent += items;
      ph++;
      settle();
    end

    settle();
    mismatch_count += expected_readings.size();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cta_pkg.sv
rtl/cta_scale.sv
rtl/cta_accum.sv
rtl/capsense_trimmed_accumulator_unit.sv
tb/tb_capsense_trimmed_accumulator_unit.sv
